// ===== hdl/csp_pkg.sv =====
// shared types, codes and constants of the cigar string parser
package csp_pkg;

    // default configuration
    localparam int LENGTH_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // fixed port widths
    localparam int CHAR_W     = 8;
    localparam int RTYPE_W    = 2;
    localparam int OPCODE_W   = 4;
    localparam int OPLEN_W    = 32;
    localparam int ERRCODE_W  = 2;
    localparam int OPCOUNT_W  = 16;
    localparam int DIGIT_W    = 4;

    // ascii characters of interest
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_I     = 8'h49;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h58;

    // bam operation codes
    localparam logic [OPCODE_W-1:0] OP_M  = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_I  = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_D  = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_N  = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_S  = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_H  = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_P  = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_EQ = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_X  = 4'd8;

    // result types
    localparam logic [RTYPE_W-1:0] RT_OP    = 2'd0;
    localparam logic [RTYPE_W-1:0] RT_END   = 2'd1;
    localparam logic [RTYPE_W-1:0] RT_ERROR = 2'd2;

    // error codes
    localparam logic [ERRCODE_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERRCODE_W-1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [ERRCODE_W-1:0] ERR_EARLY_END  = 2'd2;
    localparam logic [ERRCODE_W-1:0] ERR_UNKNOWN_OP = 2'd3;

    // class of one character
    typedef enum logic [1:0] {
        TK_DIGIT  = 2'd0,
        TK_END    = 2'd1,
        TK_LETTER = 2'd2,
        TK_OTHER  = 2'd3
    } token_kind_t;

    // classified item passed from front to back
    typedef struct packed {
        token_kind_t          kind;
        logic [DIGIT_W-1:0]   value;   // digit value or op code
    } token_t;

    // one result item
    typedef struct packed {
        logic [RTYPE_W-1:0]   result_type;
        logic [OPCODE_W-1:0]  op_code;
        logic [OPLEN_W-1:0]   op_length;
        logic                 length_overflow;
        logic [ERRCODE_W-1:0] error_code;
        logic [OPCODE_W+OPCOUNT_W-OPCODE_W-1:0] op_count;
    } result_t;

endpackage

// ===== hdl/csp_front.sv =====
// front end: accepts characters and classifies them into tokens
module csp_front
    import csp_pkg::*;
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              q_full,
    output logic              push,
    output token_t            push_token
);

    // take an item whenever the queue has room
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // character classification
    always_comb
    begin
        push_token.kind  = TK_OTHER;
        push_token.value = '0;
        if (char_code == CH_NUL)
        begin
            push_token.kind = TK_END;
        end
        else if (char_code >= CH_ZERO && char_code <= CH_NINE)
        begin
            push_token.kind  = TK_DIGIT;
            push_token.value = DIGIT_W'(char_code - CH_ZERO);
        end
        else
        begin
            unique case (char_code)
                CH_M:  begin push_token.kind = TK_LETTER; push_token.value = OP_M;  end
                CH_I:  begin push_token.kind = TK_LETTER; push_token.value = OP_I;  end
                CH_D:  begin push_token.kind = TK_LETTER; push_token.value = OP_D;  end
                CH_N:  begin push_token.kind = TK_LETTER; push_token.value = OP_N;  end
                CH_S:  begin push_token.kind = TK_LETTER; push_token.value = OP_S;  end
                CH_H:  begin push_token.kind = TK_LETTER; push_token.value = OP_H;  end
                CH_P:  begin push_token.kind = TK_LETTER; push_token.value = OP_P;  end
                CH_EQ: begin push_token.kind = TK_LETTER; push_token.value = OP_EQ; end
                CH_X:  begin push_token.kind = TK_LETTER; push_token.value = OP_X;  end
                default:
                begin
                    push_token.kind = TK_OTHER;
                end
            endcase
        end
    end

endmodule

// ===== hdl/csp_queue.sv =====
// short token queue between front and back
module csp_queue
    import csp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_token,
    input  logic   pop,
    output token_t pop_token,
    output logic   full,
    output logic   empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_token = mem[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

endmodule

// ===== hdl/csp_back.sv =====
// back end: parse state machine, length accumulator and result register
module csp_back
    import csp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  token_t  q_token,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t result
);

    localparam int PROD_W = LENGTH_BITS + 4;

    typedef enum logic [2:0] {
        PH_START   = 3'b001,
        PH_NUMBER  = 3'b010,
        PH_DISCARD = 3'b100
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                result_reg, result_next;

    logic [PROD_W-1:0]      prod;
    logic [PROD_W-1:0]      acc_ext;
    logic                   prod_over;
    logic [LENGTH_BITS+OPLEN_W-1:0] len_wide;
    logic [COUNT_BITS+OPCOUNT_W-1:0] cnt_wide;
    logic                   emit;

    // advance when the result register is free or being emptied
    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    // times ten plus digit, saturation when the sum leaves the length range
    assign acc_ext   = {4'b0, acc_reg};
    assign prod      = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(q_token.value);
    assign prod_over = (prod[PROD_W-1:LENGTH_BITS] != '0);

    assign len_wide = {{OPLEN_W{1'b0}}, acc_reg};
    assign cnt_wide = {{OPCOUNT_W{1'b0}}, cnt_reg};

    // parse step
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        cnt_next    = cnt_reg;
        emit        = 1'b0;
        result_next = '0;
        if (pop)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (q_token.kind == TK_END)
                    begin
                        emit                 = 1'b1;
                        result_next.result_type = RT_END;
                        result_next.op_count = cnt_wide[OPCOUNT_W-1:0];
                        acc_next             = '0;
                        ovf_next             = 1'b0;
                        cnt_next             = '0;
                    end
                    else if (q_token.kind == TK_DIGIT)
                    begin
                        acc_next   = LENGTH_BITS'(q_token.value);
                        ovf_next   = 1'b0;
                        phase_next = PH_NUMBER;
                    end
                    else
                    begin
                        emit                    = 1'b1;
                        result_next.result_type = RT_ERROR;
                        result_next.error_code  = ERR_UNEXPECTED;
                        phase_next              = PH_DISCARD;
                    end
                end
                PH_NUMBER:
                begin
                    unique case (q_token.kind)
                        TK_DIGIT:
                        begin
                            if (prod_over)
                            begin
                                acc_next = '1;
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = prod[LENGTH_BITS-1:0];
                            end
                        end
                        TK_END:
                        begin
                            emit                    = 1'b1;
                            result_next.result_type = RT_ERROR;
                            result_next.error_code  = ERR_EARLY_END;
                            acc_next                = '0;
                            ovf_next                = 1'b0;
                            cnt_next                = '0;
                            phase_next              = PH_START;
                        end
                        TK_LETTER:
                        begin
                            emit                        = 1'b1;
                            result_next.result_type     = RT_OP;
                            result_next.op_code         = q_token.value;
                            result_next.op_length       = len_wide[OPLEN_W-1:0];
                            result_next.length_overflow = ovf_reg;
                            if (cnt_reg != '1)
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                            acc_next   = '0;
                            ovf_next   = 1'b0;
                            phase_next = PH_START;
                        end
                        default:
                        begin
                            emit                    = 1'b1;
                            result_next.result_type = RT_ERROR;
                            result_next.error_code  = ERR_UNKNOWN_OP;
                            phase_next              = PH_DISCARD;
                        end
                    endcase
                end
                default:
                begin
                    // discard until the terminator
                    if (q_token.kind == TK_END)
                    begin
                        acc_next   = '0;
                        ovf_next   = 1'b0;
                        cnt_next   = '0;
                        phase_next = PH_START;
                    end
                end
            endcase
        end
    end

    // output valid: load on a new result, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== hdl/cigar_string_parser.sv =====
// top level of the cigar string parser
// a character goes through the token queue and then the result register to the output
// throughput: one character per cycle while no result stalls; tokens pop as results go
// while a result is stalled the token queue (two entries by default) fills, then stalls
// reset: rst_n asynchronous active low; clears phase, length, overflow, count and queue
// after reset the block expects the start of a number and holds no result
module cigar_string_parser
    import csp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CHAR_W-1:0]    char_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [RTYPE_W-1:0]   result_type,
    output logic [OPCODE_W-1:0]  op_code,
    output logic [OPLEN_W-1:0]   op_length,
    output logic                 length_overflow,
    output logic [ERRCODE_W-1:0] error_code,
    output logic [OPCOUNT_W-1:0] op_count
);

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    token_t  push_token;
    token_t  pop_token;
    result_t result;

    // character classifier
    csp_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .q_full     (q_full),
        .push       (push),
        .push_token (push_token)
    );

    // token queue
    csp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .pop_token  (pop_token),
        .full       (q_full),
        .empty      (q_empty)
    );

    // parser state machine
    csp_back #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_token   (pop_token),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // result fields
    assign result_type     = result.result_type;
    assign op_code         = result.op_code;
    assign op_length       = result.op_length;
    assign length_overflow = result.length_overflow;
    assign error_code      = result.error_code;
    assign op_count        = result.op_count;

endmodule

// ===== hdl/csp_checker.sv =====
// port-level checks of the cigar string parser and their binding
module csp_checker
    import csp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [RTYPE_W-1:0]   result_type,
    input logic [OPCODE_W-1:0]  op_code,
    input logic [OPLEN_W-1:0]   op_length,
    input logic                 length_overflow,
    input logic [ERRCODE_W-1:0] error_code,
    input logic [OPCOUNT_W-1:0] op_count
);

    // a stalled item stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_type) && $stable(op_code)
            && $stable(op_length) && $stable(error_code) && $stable(op_count))
        else $error("stalled result changed");

    // operation items carry a known code and no error or count
    a_op: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_type == RT_OP |->
            op_code <= OP_X && error_code == ERR_NONE && op_count == '0)
        else $error("bad operation result");

    // end items carry only the count
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_type == RT_END |->
            op_code == '0 && op_length == '0 && !length_overflow && error_code == ERR_NONE)
        else $error("bad end result");

    // error items carry a nonzero code and no length, overflow or count
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_type == RT_ERROR |->
            error_code != ERR_NONE && op_length == '0 && op_count == '0 && !length_overflow)
        else $error("bad error result");

    // no unused result type
    a_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_type == RT_OP || result_type == RT_END
            || result_type == RT_ERROR)
        else $error("unknown result type");

endmodule

bind cigar_string_parser csp_checker u_csp_checker (.*);
